// ----- rtl/tibr_pkg.sv -----
// ----------------------------------------------------------------------------
// tibr_pkg
// Shared constants, types and codes of the thread ID bitmap registry.
// ----------------------------------------------------------------------------
package tibr_pkg;

  // Bitmap geometry.
  localparam int unsigned BITMAP_WORDS = 32;
  localparam int unsigned WORD_BITS    = 32;
  localparam int unsigned BIT_AW       = $clog2(WORD_BITS);
  localparam int unsigned WORD_AW      = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int unsigned MAX_ID       = BITMAP_WORDS * WORD_BITS;

  // Field widths.
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned ID_W     = 11;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned TOTAL_W  = 32;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [WORD_AW-1:0]   word_addr_t;
  typedef logic [BIT_AW-1:0]    bit_idx_t;
  typedef logic [ID_W-1:0]      id_t;
  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [TOTAL_W-1:0]   total_t;

  localparam word_t      FULL_WORD = '1;
  localparam word_addr_t LAST_WORD = WORD_AW'(BITMAP_WORDS - 1);
  localparam count_t     COUNT_MAX = '1;
  localparam total_t     TOTAL_MAX = '1;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC    = 2'd0,
    CMD_START    = 2'd1,
    CMD_EXIT     = 2'd2,
    CMD_PEAK_RST = 2'd3
  } cmd_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXIT,
    S_DONE
  } state_e;

  // Bitmap memory access request.
  typedef struct packed {
    logic       rd_en;
    word_addr_t rd_addr;
    logic       wr_en;
    word_addr_t wr_addr;
    word_t      wr_data;
  } mem_req_t;

  // Completion of one command, from the controller.
  typedef struct packed {
    logic    fire;
    logic    start_ok;
    logic    exit_ok;
    logic    peak_rst;
    logic    daemon;
    id_t     assigned;
    status_e status;
  } fin_t;

  // Thread counts.
  typedef struct packed {
    count_t live;
    count_t peak;
    total_t total;
    count_t non_daemon;
  } cnt_t;

endpackage

// ----- rtl/tibr_if.sv -----
// ----------------------------------------------------------------------------
// tibr_if
// Command and response channels of the thread ID bitmap registry.
// ----------------------------------------------------------------------------
interface tibr_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic        daemon;
  logic [10:0] free_id;

  modport source (output valid, command, daemon, free_id, input ready);
  modport sink   (input valid, command, daemon, free_id, output ready);
endinterface

interface tibr_rsp_if;
  logic        valid;
  logic        ready;
  logic [10:0] assigned_id;
  logic [1:0]  status;
  logic [10:0] live_count;
  logic [10:0] peak_count;
  logic [31:0] total_started;
  logic [10:0] non_daemon_count;

  modport source (output valid, assigned_id, status, live_count, peak_count,
                  total_started, non_daemon_count, input ready);
  modport sink   (input valid, assigned_id, status, live_count, peak_count,
                  total_started, non_daemon_count, output ready);
endinterface

// ----- rtl/tibr_bitmap_ram.sv -----
// ----------------------------------------------------------------------------
// tibr_bitmap_ram
// Bitmap word store: one write and one registered read per cycle. A word
// that was never written since reset reads as all zeros (every ID free).
// ----------------------------------------------------------------------------
module tibr_bitmap_ram (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tibr_pkg::mem_req_t req_i,
  output tibr_pkg::word_t    rd_data_o
);
  import tibr_pkg::*;

  word_t                   mem_q [BITMAP_WORDS];
  logic [BITMAP_WORDS-1:0] wvalid_q;
  word_t                   rd_data_q;
  logic                    rd_valid_q;

  // Storage array and read data register.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  // Per-word written flags, cleared at reset, and the flag of the word read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wvalid_q   <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        wvalid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= wvalid_q[req_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

// ----- rtl/tibr_ctrl.sv -----
// ----------------------------------------------------------------------------
// tibr_ctrl
// Command sequencer: scans the bitmap one word per cycle for a free ID,
// clears IDs on exit, and reports each finished command.
// ----------------------------------------------------------------------------
module tibr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  logic [1:0]         command_i,
  input  logic               daemon_i,
  input  tibr_pkg::id_t      free_id_i,
  input  logic               out_free_i,
  input  tibr_pkg::word_t    rd_data_i,
  output tibr_pkg::mem_req_t mem_req_o,
  output tibr_pkg::fin_t     fin_o
);
  import tibr_pkg::*;

  state_e     state_q, state_d;
  cmd_e       cmd_q, cmd_d;
  logic       daemon_q, daemon_d;
  word_addr_t word_q, word_d;
  bit_idx_t   bit_q, bit_d;
  id_t        assigned_q, assigned_d;
  status_e    status_q, status_d;

  cmd_e       cmd_in;
  id_t        fid_m1;
  logic       fid_bad;
  bit_idx_t   free_bit;
  logic       accept;

  assign cmd_in  = cmd_e'(command_i);
  assign fid_m1  = free_id_i - ID_W'(1);
  assign fid_bad = (free_id_i == '0) || (32'(free_id_i) > MAX_ID);
  assign accept  = cmd_valid_i && cmd_ready_o;

  // Lowest clear bit of the word being scanned.
  always_comb begin
    free_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!rd_data_i[i]) begin
        free_bit = BIT_AW'(i);
      end
    end
  end

  // State and command registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    daemon_q   <= daemon_d;
    word_q     <= word_d;
    bit_q      <= bit_d;
    assigned_q <= assigned_d;
    status_q   <= status_d;
  end

  // Next state, memory requests and completion.
  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    daemon_d   = daemon_q;
    word_d     = word_q;
    bit_d      = bit_q;
    assigned_d = assigned_q;
    status_d   = status_q;
    mem_req_o  = '0;
    fin_o      = '0;
    cmd_ready_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (accept) begin
          cmd_d      = cmd_in;
          daemon_d   = daemon_i;
          assigned_d = '0;
          status_d   = ST_OK;
          unique case (cmd_in)
            CMD_ALLOC, CMD_START: begin
              // Start the scan at word zero.
              mem_req_o.rd_en   = 1'b1;
              mem_req_o.rd_addr = '0;
              word_d            = '0;
              state_d           = S_SCAN;
            end
            CMD_EXIT: begin
              if (fid_bad) begin
                status_d = ST_INVALID;
                state_d  = S_DONE;
              end else begin
                mem_req_o.rd_en   = 1'b1;
                mem_req_o.rd_addr = WORD_AW'(fid_m1 >> BIT_AW);
                word_d            = WORD_AW'(fid_m1 >> BIT_AW);
                bit_d             = fid_m1[BIT_AW-1:0];
                state_d           = S_EXIT;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (rd_data_i != FULL_WORD) begin
          // Claim the lowest free bit of this word.
          mem_req_o.wr_en   = 1'b1;
          mem_req_o.wr_addr = word_q;
          mem_req_o.wr_data = rd_data_i | (word_t'(1) << free_bit);
          assigned_d        = ID_W'({word_q, free_bit}) + ID_W'(1);
          state_d           = S_DONE;
        end else if (word_q == LAST_WORD) begin
          status_d = ST_FULL;
          state_d  = S_DONE;
        end else begin
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = word_q + WORD_AW'(1);
          word_d            = word_q + WORD_AW'(1);
        end
      end

      S_EXIT: begin
        // Release the ID, whether or not it was in use.
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_addr = word_q;
        mem_req_o.wr_data = rd_data_i & ~(word_t'(1) << bit_q);
        state_d           = S_DONE;
      end

      S_DONE: begin
        if (out_free_i) begin
          fin_o.fire     = 1'b1;
          fin_o.start_ok = (cmd_q == CMD_START) && (status_q == ST_OK);
          fin_o.exit_ok  = (cmd_q == CMD_EXIT) && (status_q == ST_OK);
          fin_o.peak_rst = (cmd_q == CMD_PEAK_RST);
          fin_o.daemon   = daemon_q;
          fin_o.assigned = assigned_q;
          fin_o.status   = status_q;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // A write and a read never target the same word in one cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req_o.wr_en && mem_req_o.rd_en && (mem_req_o.wr_addr == mem_req_o.rd_addr)))
    else $error("bitmap read and write collide on one word");

  // At most one count update kind per completed transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_o.fire |-> $onehot0({fin_o.start_ok, fin_o.exit_ok, fin_o.peak_rst}))
    else $error("conflicting count updates");

  // A successful claim always yields a nonzero ID.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && mem_req_o.wr_en) |=> (assigned_q != '0 && status_q == ST_OK))
    else $error("claimed word but no ID recorded");

  // An accepted transaction always leaves idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE))
    else $error("accepted command did not start");

endmodule

// ----- rtl/tibr_counters.sv -----
// ----------------------------------------------------------------------------
// tibr_counters
// Live, peak, total and non-daemon thread counts with saturation.
// ----------------------------------------------------------------------------
module tibr_counters (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tibr_pkg::fin_t fin_i,
  output tibr_pkg::cnt_t cnt_d_o
);
  import tibr_pkg::*;

  cnt_t   cnt_q, cnt_d;
  count_t live_inc, live_dec, nd_inc, nd_dec;

  assign live_inc = (cnt_q.live == COUNT_MAX) ? cnt_q.live : cnt_q.live + COUNT_W'(1);
  assign live_dec = (cnt_q.live == '0) ? cnt_q.live : cnt_q.live - COUNT_W'(1);
  assign nd_inc   = (cnt_q.non_daemon == COUNT_MAX) ? cnt_q.non_daemon
                                                    : cnt_q.non_daemon + COUNT_W'(1);
  assign nd_dec   = (cnt_q.non_daemon == '0) ? cnt_q.non_daemon
                                             : cnt_q.non_daemon - COUNT_W'(1);

  // Count values after the completing transaction.
  always_comb begin
    cnt_d = cnt_q;
    if (fin_i.fire) begin
      if (fin_i.start_ok) begin
        cnt_d.live = live_inc;
        if (live_inc > cnt_q.peak) begin
          cnt_d.peak = live_inc;
        end
        if (cnt_q.total != TOTAL_MAX) begin
          cnt_d.total = cnt_q.total + TOTAL_W'(1);
        end
        if (!fin_i.daemon) begin
          cnt_d.non_daemon = nd_inc;
        end
      end else if (fin_i.exit_ok) begin
        cnt_d.live = live_dec;
        if (!fin_i.daemon) begin
          cnt_d.non_daemon = nd_dec;
        end
      end else if (fin_i.peak_rst) begin
        cnt_d.peak = cnt_q.live;
      end
    end
  end

  // Count registers; the main thread is counted from reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q.live       <= COUNT_W'(1);
      cnt_q.peak       <= COUNT_W'(1);
      cnt_q.total      <= TOTAL_W'(1);
      cnt_q.non_daemon <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign cnt_d_o = cnt_d;

  // The peak never falls below the live count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q.peak >= cnt_q.live)
    else $error("peak count below live count");

  // Counts only move when a transaction completes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fin_i.fire |=> $stable(cnt_q))
    else $error("counts changed without a completed command");

endmodule

// ----- rtl/thread_id_bitmap_registry_unit.sv -----
// ----------------------------------------------------------------------------
// thread_id_bitmap_registry_unit
// Thread ID allocator over a bitmap of 32-bit words, with thread counts.
// ----------------------------------------------------------------------------
// One command is in flight at a time. An allocate or start command reads
// the bitmap from word zero up to the first word that still has a clear
// bit, or up to the last word when the bitmap is full; the bitmap memory
// delivers one word per cycle and the scan walks it in order. An exit does
// a read-modify-write of one word, and a peak reset or an out-of-range exit
// touches no bitmap word. The response sits in an output register, so a new
// command is taken while the previous response waits; a command finishes
// only once that register is free. The bitmap reads as all free right after
// reset without a clearing pass.
// ----------------------------------------------------------------------------
module thread_id_bitmap_registry_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  tibr_cmd_if.sink   cmd_i,
  tibr_rsp_if.source rsp_o
);
  import tibr_pkg::*;

  mem_req_t mem_req;
  word_t    rd_data;
  fin_t     fin;
  cnt_t     cnt_d;
  logic     out_free;

  logic     out_valid_q;
  id_t      out_assigned_q;
  logic [STATUS_W-1:0] out_status_q;
  cnt_t     out_cnt_q;

  assign out_free = !out_valid_q || rsp_o.ready;

  tibr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_ready_o (cmd_i.ready),
    .command_i   (cmd_i.command),
    .daemon_i    (cmd_i.daemon),
    .free_id_i   (cmd_i.free_id),
    .out_free_i  (out_free),
    .rd_data_i   (rd_data),
    .mem_req_o   (mem_req),
    .fin_o       (fin)
  );

  tibr_bitmap_ram u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  tibr_counters u_counters (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fin_i   (fin),
    .cnt_d_o (cnt_d)
  );

  // Response valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin.fire) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Response payload register.
  always_ff @(posedge clk_i) begin
    if (fin.fire) begin
      out_assigned_q <= fin.assigned;
      out_status_q   <= fin.status;
      out_cnt_q      <= cnt_d;
    end
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.assigned_id      = out_assigned_q;
  assign rsp_o.status           = out_status_q;
  assign rsp_o.live_count       = out_cnt_q.live;
  assign rsp_o.peak_count       = out_cnt_q.peak;
  assign rsp_o.total_started    = out_cnt_q.total;
  assign rsp_o.non_daemon_count = out_cnt_q.non_daemon;

  // A finished command never overwrites a response still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !rsp_o.ready) |-> !fin.fire)
    else $error("response overwritten before transaction");

  // A failed status (full or invalid) never carries an ID.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q != ST_OK) |-> (out_assigned_q == '0))
    else $error("failed command reports an ID");

  // No command is accepted while another one is being processed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.valid && cmd_i.ready) |=> !cmd_i.ready)
    else $error("second command accepted while busy");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the thread ID bitmap registry. A clocked driver
// feeds commands from a queue and predicts each reply when its transaction
// is accepted. A clocked monitor compares every reply with the oldest
// prediction. A directed opening is followed by random phases with varied
// idling, including one phase that runs the bitmap full.
// ----------------------------------------------------------------------------
module testbench;
  import tibr_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned RESET_CYCLES = 11;

  typedef struct {
    cmd_e   command;
    logic   daemon;
    id_t    free_id;
  } command_t;

  typedef struct {
    id_t     assigned_id;
    status_e status;
    count_t  live;
    count_t  peak;
    total_t  total;
    count_t  non_daemon;
  } reply_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  tibr_cmd_if cmd_bus ();
  tibr_rsp_if rsp_bus ();

  thread_id_bitmap_registry_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_bus),
    .rsp_o  (rsp_bus)
  );

  always #5 clk_i = ~clk_i;

  // Shadow registry state.
  word_t  id_map [BITMAP_WORDS];
  count_t live_cnt;
  count_t peak_cnt;
  total_t started_cnt;
  count_t nondaemon_cnt;

  command_t queued_commands [$];
  reply_t   awaited_replies [$];
  command_t in_flight;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned bad_replies;
  int unsigned cycle_count;

  // Applies one command to the shadow registry and returns its reply.
  function automatic reply_t apply_command(command_t c);
    reply_t      r;
    logic        found;
    int unsigned slot;
    r.assigned_id = '0;
    r.status      = ST_OK;
    found         = 1'b0;
    case (c.command)
      CMD_ALLOC, CMD_START: begin
        // Lowest clear bit, words in order.
        for (int unsigned w = 0; w < BITMAP_WORDS; w++) begin
          for (int unsigned b = 0; b < WORD_BITS; b++) begin
            if (!found && !id_map[w][b]) begin
              id_map[w][b]  = 1'b1;
              r.assigned_id = id_t'(w * WORD_BITS + b + 1);
              found         = 1'b1;
            end
          end
        end
        if (!found) begin
          r.status = ST_FULL;
        end else if (c.command == CMD_START) begin
          if (live_cnt != COUNT_MAX) live_cnt++;
          if (live_cnt > peak_cnt) peak_cnt = live_cnt;
          if (started_cnt != TOTAL_MAX) started_cnt++;
          if (!c.daemon && nondaemon_cnt != COUNT_MAX) nondaemon_cnt++;
        end
      end
      CMD_EXIT: begin
        if (c.free_id == '0 || c.free_id > MAX_ID) begin
          r.status = ST_INVALID;
        end else begin
          // Freeing an unused ID still lowers the counts.
          slot = c.free_id - 1;
          id_map[slot / WORD_BITS][slot % WORD_BITS] = 1'b0;
          if (live_cnt != '0) live_cnt--;
          if (!c.daemon && nondaemon_cnt != '0) nondaemon_cnt--;
        end
      end
      default: begin
        peak_cnt = live_cnt;
      end
    endcase
    r.live       = live_cnt;
    r.peak       = peak_cnt;
    r.total      = started_cnt;
    r.non_daemon = nondaemon_cnt;
    return r;
  endfunction

  // Random command; the peak reset takes the weight left over from 100.
  function automatic command_t random_command(int unsigned w_alloc, int unsigned w_start,
                                              int unsigned w_exit, int unsigned id_hi);
    command_t    c;
    int unsigned pick;
    pick        = $urandom_range(99);
    c.daemon    = 1'($urandom_range(1));
    c.free_id   = id_t'($urandom_range(2047));
    if (pick < w_alloc) begin
      c.command = CMD_ALLOC;
    end else if (pick < w_alloc + w_start) begin
      c.command = CMD_START;
    end else if (pick < w_alloc + w_start + w_exit) begin
      c.command = CMD_EXIT;
      // Mostly IDs that may be in use; the rest is any field value.
      if ($urandom_range(9) != 0) c.free_id = id_t'($urandom_range(id_hi, 1));
    end else begin
      c.command = CMD_PEAK_RST;
    end
    return c;
  endfunction

  task automatic queue_command(cmd_e command, logic daemon, id_t free_id);
    command_t c;
    c.command   = command;
    c.daemon    = daemon;
    c.free_id   = free_id;
    queued_commands.push_back(c);
  endtask

  // Holds off until every queued command has been sent and answered.
  task automatic wait_replies();
    do begin
      @(posedge clk_i);
    end while (queued_commands.size() != 0 || cmd_bus.valid || awaited_replies.size() != 0);
  endtask

  // Driver: predict on acceptance, then present the next command or idle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_bus.valid     <= 1'b0;
      cmd_bus.command   <= CMD_ALLOC;
      cmd_bus.daemon    <= 1'b0;
      cmd_bus.free_id   <= '0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        awaited_replies.push_back(apply_command(in_flight));
      end
      if (!cmd_bus.valid || cmd_bus.ready) begin
        if (queued_commands.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_flight          = queued_commands.pop_front();
          cmd_bus.valid     <= 1'b1;
          cmd_bus.command   <= in_flight.command;
          cmd_bus.daemon    <= in_flight.daemon;
          cmd_bus.free_id   <= in_flight.free_id;
        end else begin
          cmd_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Compares one accepted reply with the oldest prediction.
  task automatic check_reply();
    reply_t want;
    if (awaited_replies.size() == 0) begin
      bad_replies++;
      if (bad_replies <= REPORT_LIMIT) begin
        $display("%0t: reply with nothing awaited: id=%0d status=%0d live=%0d peak=%0d",
                 $realtime, rsp_bus.assigned_id, rsp_bus.status, rsp_bus.live_count,
                 rsp_bus.peak_count);
      end
    end else begin
      want = awaited_replies.pop_front();
      if (rsp_bus.assigned_id !== want.assigned_id || rsp_bus.status !== want.status ||
          rsp_bus.live_count !== want.live || rsp_bus.peak_count !== want.peak ||
          rsp_bus.total_started !== want.total ||
          rsp_bus.non_daemon_count !== want.non_daemon) begin
        bad_replies++;
        if (bad_replies <= REPORT_LIMIT) begin
          $display("%0t: reply mismatch, expected id=%0d status=%0d live=%0d peak=%0d",
                   $realtime, want.assigned_id, want.status, want.live, want.peak,
                   " total=%0d non_daemon=%0d", want.total, want.non_daemon);
          $display("    actual id=%0d status=%0d live=%0d peak=%0d total=%0d non_daemon=%0d",
                   rsp_bus.assigned_id, rsp_bus.status, rsp_bus.live_count,
                   rsp_bus.peak_count, rsp_bus.total_started, rsp_bus.non_daemon_count);
        end
      end
    end
  endtask

  // Monitor: check accepted replies and stall at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) check_reply();
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int unsigned n_alloc;
    command_t    c;

    // Known inputs from time zero, and the shadow state after reset.
    cmd_bus.valid     = 1'b0;
    cmd_bus.command   = CMD_ALLOC;
    cmd_bus.daemon    = 1'b0;
    cmd_bus.free_id   = '0;
    rsp_bus.ready     = 1'b0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    bad_replies       = 0;
    cycle_count       = 0;
    for (int unsigned w = 0; w < BITMAP_WORDS; w++) id_map[w] = '0;
    live_cnt      = 1;
    peak_cnt      = 1;
    started_cnt   = 1;
    nondaemon_cnt = 0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening: every command, invalid IDs, counts driven to zero.
    queue_command(CMD_ALLOC,    1'b0, 11'd0);
    queue_command(CMD_START,    1'b0, 11'd0);
    queue_command(CMD_START,    1'b1, 11'd0);
    queue_command(CMD_PEAK_RST, 1'b0, 11'd0);
    queue_command(CMD_EXIT,     1'b0, 11'd2);
    queue_command(CMD_EXIT,     1'b1, 11'd3);
    queue_command(CMD_EXIT,     1'b0, 11'd0);
    queue_command(CMD_EXIT,     1'b0, 11'd1025);
    queue_command(CMD_EXIT,     1'b1, 11'd2047);
    // Highest legal ID, never in use: the live count still drops.
    queue_command(CMD_EXIT,     1'b0, 11'd1024);
    // Live and non-daemon counts already at zero stay there.
    queue_command(CMD_EXIT,     1'b0, 11'd500);
    queue_command(CMD_EXIT,     1'b1, 11'd33);
    queue_command(CMD_PEAK_RST, 1'b1, 11'd2047);
    queue_command(CMD_START,    1'b0, 11'd2047);
    queue_command(CMD_ALLOC,    1'b1, 11'd2047);
    queue_command(CMD_START,    1'b1, 11'd1365);
    queue_command(CMD_EXIT,     1'b1, 11'd1);
    queue_command(CMD_ALLOC,    1'b0, 11'd682);
    queue_command(CMD_PEAK_RST, 1'b0, 11'd0);
    wait_replies();

    // Mixed traffic over low IDs, no idling.
    for (int i = 0; i < 40; i++) queued_commands.push_back(random_command(20, 35, 35, 96));
    wait_replies();

    // Run the bitmap full and beyond, with an idle sender.
    send_idle_pct = 83;
    n_alloc       = 0;
    while (n_alloc < MAX_ID + 16) begin
      c = random_command(48, 49, 0, 1);
      if (c.command == CMD_ALLOC || c.command == CMD_START) n_alloc++;
      queued_commands.push_back(c);
    end
    wait_replies();

    // Exits across the whole map with refills into the holes, stalled receiver.
    send_idle_pct  = 0;
    recv_stall_pct = 83;
    for (int i = 0; i < 60; i++) begin
      queued_commands.push_back(random_command(10, 30, 50, MAX_ID));
    end
    wait_replies();

    // Light idling on both sides.
    send_idle_pct  = 7;
    recv_stall_pct = 7;
    for (int i = 0; i < 40; i++) begin
      queued_commands.push_back(random_command(20, 30, 40, MAX_ID));
    end
    wait_replies();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (bad_replies == 0 && awaited_replies.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/tibr_pkg.sv
rtl/tibr_if.sv
rtl/tibr_bitmap_ram.sv
rtl/tibr_ctrl.sv
rtl/tibr_counters.sv
rtl/thread_id_bitmap_registry_unit.sv
tb/sv/testbench.sv
